@@ hdl/ptt_pkg.sv @@
// Package: shared constants, codes and controller/datapath command types.
`timescale 1ns / 1ps
package ptt_pkg;
  localparam int unsigned SlotsDef = 16;
  localparam int unsigned TimeW = 48;
  localparam logic [31:0] TimeoutRst = 32'd5000;

  localparam logic [2:0] CmdAlloc   = 3'd0;
  localparam logic [2:0] CmdFind    = 3'd1;
  localparam logic [2:0] CmdSet     = 3'd2;
  localparam logic [2:0] CmdRelease = 3'd3;
  localparam logic [2:0] CmdSweep   = 3'd4;

  localparam logic [1:0] RcOk      = 2'd0;
  localparam logic [1:0] RcFull    = 2'd1;
  localparam logic [1:0] RcMiss    = 2'd2;
  localparam logic [1:0] RcNotBusy = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch input word
    logic start;    // load walk cursor from busy head, clear expired count
    logic restart;  // reload walk cursor from busy head, keep expired count
    logic step;     // advance cursor to next_link
    logic tally;    // sweep count pass: cursor entry expired
    logic do_alloc;
    logic do_set;
    logic do_free_slot; // release addressed slot
    logic do_free_cur;  // sweep: free entry at cursor
    logic emit;         // load output register
    logic [1:0] code;
    logic use_cur;      // output carries cursor entry data
    logic use_slot;     // output carries addressed slot
    logic drop;
    logic last;
  } ptt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] command;
    logic full;
    logic slot_ok;
    logic cur_valid;  // cursor names a slot and walk budget left
    logic match;
    logic expired;
    logic any_drop;   // expired entries still to be reported
    logic last_drop;  // exactly one expired entry left
    logic out_busy;
  } ptt_stat_t;
endpackage

@@ hdl/ptt_datapath.sv @@
// Datapath: entry stores, link lists, walk cursor and output register.
`timescale 1ns / 1ps
module ptt_datapath
  import ptt_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptt_cmd_t             cmd_i,
  output ptt_stat_t            stat_o,
  input  logic                 cfg_valid,
  input  logic [31:0]          cfg_data,
  input  logic [2:0]           command_i,
  input  logic [3:0]           slot_i,
  input  logic [1:0]           entry_status_i,
  input  logic [31:0]          sender_addr_i,
  input  logic [31:0]          receiver_addr_i,
  input  logic [31:0]          amount_in_i,
  input  logic [TimeW-1:0]     now_ms_i,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           result_code_o,
  output logic [3:0]           slot_out_o,
  output logic                 dropped_o,
  output logic [31:0]          sender_out_o,
  output logic [31:0]          receiver_out_o,
  output logic [31:0]          amount_out_o,
  output logic [4:0]           free_count_o,
  output logic                 last_o
);
  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] NoneL = LW'(SLOTS);

  logic [1:0]        st_mem [SLOTS];
  logic [31:0]       snd_mem [SLOTS];
  logic [31:0]       rcv_mem [SLOTS];
  logic [31:0]       amt_mem [SLOTS];
  logic [TimeW-1:0]  cre_mem [SLOTS];
  logic [LW-1:0]     next_q [SLOTS];
  logic [LW-1:0]     prev_q [SLOTS];
  logic [SLOTS-1:0]  busy_q;
  logic [LW-1:0]     bhead_q, ihead_q, cur_q;
  logic [LW-1:0]     icount_q, steps_q;
  logic [LW-1:0]     exp_cnt_q;
  logic [31:0]       timeout_q;

  logic [2:0]        c_cmd_q;
  logic [3:0]        c_slot_q;
  logic [1:0]        c_st_q;
  logic [31:0]       c_snd_q, c_rcv_q, c_amt_q;
  logic [TimeW-1:0]  c_now_q;

  logic [IW-1:0]     cur_ix, slot_ix, ihead_ix;
  logic [TimeW-1:0]  age;
  logic              slot_in_range;

  assign cur_ix   = cur_q[IW-1:0];
  assign ihead_ix = ihead_q[IW-1:0];
  assign slot_in_range = ({{(32-4){1'b0}}, c_slot_q} < 32'(SLOTS));
  assign slot_ix  = IW'(c_slot_q);
  assign age      = c_now_q - cre_mem[cur_ix];

  assign stat_o.command   = c_cmd_q;
  assign stat_o.full      = (icount_q == '0) || (ihead_q >= NoneL);
  assign stat_o.slot_ok   = slot_in_range && busy_q[slot_ix];
  assign stat_o.cur_valid = (cur_q < NoneL) && (steps_q < NoneL);
  assign stat_o.match     = (st_mem[cur_ix] == c_st_q) && (snd_mem[cur_ix] == c_snd_q)
                            && (rcv_mem[cur_ix] == c_rcv_q);
  assign stat_o.expired   = age > {{(TimeW-32){1'b0}}, timeout_q};
  assign stat_o.out_busy  = out_valid;
  assign stat_o.any_drop  = (exp_cnt_q != '0);
  assign stat_o.last_drop = (exp_cnt_q == LW'(1));

  // unlink/push target: addressed slot or cursor
  logic [IW-1:0] fx;
  logic          do_free;
  assign do_free = cmd_i.do_free_slot | cmd_i.do_free_cur;
  assign fx      = cmd_i.do_free_cur ? cur_ix : slot_ix;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      c_cmd_q  <= command_i;
      c_slot_q <= slot_i;
      c_st_q   <= entry_status_i;
      c_snd_q  <= sender_addr_i;
      c_rcv_q  <= receiver_addr_i;
      c_amt_q  <= amount_in_i;
      c_now_q  <= now_ms_i;
    end
    if (cmd_i.do_alloc) begin
      st_mem[ihead_ix]  <= c_st_q;
      snd_mem[ihead_ix] <= c_snd_q;
      rcv_mem[ihead_ix] <= c_rcv_q;
      amt_mem[ihead_ix] <= c_amt_q;
      cre_mem[ihead_ix] <= c_now_q;
    end
    if (cmd_i.do_set) st_mem[slot_ix] <= c_st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        next_q[i] <= LW'(i + 1);
        prev_q[i] <= (i == 0) ? NoneL : LW'(i - 1);
      end
      busy_q     <= '0;
      bhead_q    <= NoneL;
      ihead_q    <= '0;
      icount_q   <= NoneL;
      cur_q      <= NoneL;
      steps_q    <= '0;
      timeout_q  <= TimeoutRst;
      exp_cnt_q  <= '0;
    end else begin
      if (cfg_valid) timeout_q <= cfg_data;
      if (cmd_i.start) begin
        cur_q     <= bhead_q;
        steps_q   <= '0;
        exp_cnt_q <= '0;
      end
      if (cmd_i.restart) begin
        cur_q   <= bhead_q;
        steps_q <= '0;
      end
      if (cmd_i.step) begin
        cur_q   <= next_q[cur_ix];
        steps_q <= steps_q + 1'b1;
      end
      if (cmd_i.tally) exp_cnt_q <= exp_cnt_q + 1'b1;
      if (cmd_i.do_free_cur) exp_cnt_q <= exp_cnt_q - 1'b1;
      if (cmd_i.do_alloc) begin
        // unlink idle head (its prev is none), push onto busy list
        automatic logic [LW-1:0] n = next_q[ihead_ix];
        ihead_q <= n;
        if (n < NoneL) prev_q[n[IW-1:0]] <= NoneL;
        prev_q[ihead_ix] <= NoneL;
        next_q[ihead_ix] <= bhead_q;
        if (bhead_q < NoneL) prev_q[bhead_q[IW-1:0]] <= ihead_q;
        bhead_q  <= ihead_q;
        icount_q <= icount_q - 1'b1;
        busy_q[ihead_ix] <= 1'b1;
      end
      if (do_free) begin
        automatic logic [LW-1:0] n = next_q[fx];
        automatic logic [LW-1:0] p = prev_q[fx];
        automatic logic [LW-1:0] bh = bhead_q;
        if (p >= NoneL) bh = n;
        else next_q[p[IW-1:0]] <= n;
        if (n < NoneL) prev_q[n[IW-1:0]] <= p;
        bhead_q <= bh;
        prev_q[fx] <= NoneL;
        next_q[fx] <= ihead_q;
        if (ihead_q < NoneL) prev_q[ihead_ix] <= LW'(fx);
        ihead_q  <= LW'(fx);
        icount_q <= icount_q + 1'b1;
        busy_q[fx] <= 1'b0;
      end
    end
  end

  // output register; a sweep report carries the idle count after the whole sweep
  logic [4:0] cnt_after;
  always_comb begin
    cnt_after = 5'(icount_q);
    if (cmd_i.do_alloc) cnt_after = cnt_after - 5'd1;
    if (cmd_i.do_free_slot) cnt_after = cnt_after + 5'd1;
    if (cmd_i.do_free_cur) cnt_after = 5'(icount_q) + 5'(exp_cnt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      result_code_o  <= cmd_i.code;
      slot_out_o     <= cmd_i.use_cur ? 4'(cur_ix) :
                        cmd_i.use_slot ? c_slot_q :
                        cmd_i.do_alloc ? 4'(ihead_ix) : 4'd0;
      dropped_o      <= cmd_i.drop;
      sender_out_o   <= cmd_i.use_cur ? snd_mem[cur_ix] : 32'd0;
      receiver_out_o <= cmd_i.use_cur ? rcv_mem[cur_ix] : 32'd0;
      amount_out_o   <= cmd_i.use_cur ? amt_mem[cur_ix] : 32'd0;
      free_count_o   <= cnt_after;
      last_o         <= cmd_i.last;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_alloc |-> !busy_q[ihead_ix])
    else $error("allocating a busy slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.do_free_cur |-> busy_q[cur_ix])
    else $error("sweep freeing an idle slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    icount_q <= NoneL)
    else $error("idle count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !out_valid || out_ready)
    else $error("output overwritten");
endmodule

@@ hdl/ptt_ctrl.sv @@
// Controller: sequences each command word over the datapath.
`timescale 1ns / 1ps
module ptt_ctrl
  import ptt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid,
  output logic      in_ready,
  input  ptt_stat_t stat_i,
  output ptt_cmd_t  cmd_o
);
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SExec  = 3'd1;
  localparam logic [2:0] SFind  = 3'd2;
  localparam logic [2:0] SSweep = 3'd3;
  localparam logic [2:0] SWait  = 3'd4;
  localparam logic [2:0] SDrop  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       free_out;
  assign free_out = !stat_i.out_busy;  // out reg empty or being drained this cycle is
                                       // not assumed; wait for empty
  assign in_ready = (state_q == SIdle);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      SIdle: if (in_valid) begin
        cmd_o.capture = 1'b1;
        state_d = SExec;
      end
      SExec: if (free_out) begin
        unique case (stat_i.command) inside
          CmdAlloc: begin
            cmd_o.emit = 1'b1; cmd_o.last = 1'b1;
            if (stat_i.full) cmd_o.code = RcFull;
            else cmd_o.do_alloc = 1'b1;
            state_d = SWait;
          end
          CmdFind: begin
            cmd_o.start = 1'b1; state_d = SFind;
          end
          CmdSet, CmdRelease: begin
            cmd_o.emit = 1'b1; cmd_o.last = 1'b1; cmd_o.use_slot = 1'b1;
            if (!stat_i.slot_ok) cmd_o.code = RcNotBusy;
            else if (stat_i.command == CmdSet) cmd_o.do_set = 1'b1;
            else cmd_o.do_free_slot = 1'b1;
            state_d = SWait;
          end
          CmdSweep: begin
            cmd_o.start = 1'b1; state_d = SSweep;
          end
          default: begin
            cmd_o.emit = 1'b1; cmd_o.last = 1'b1; state_d = SWait;
          end
        endcase
      end
      SFind: begin
        if (!stat_i.cur_valid) begin
          cmd_o.emit = 1'b1; cmd_o.last = 1'b1; cmd_o.code = RcMiss;
          state_d = SWait;
        end else if (stat_i.match) begin
          cmd_o.emit = 1'b1; cmd_o.last = 1'b1; cmd_o.use_cur = 1'b1;
          state_d = SWait;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      SSweep: begin
        // count pass: every report must carry the final idle count and the
        // last flag, so the expired entries are counted before any is freed
        if (!stat_i.cur_valid) begin
          if (!stat_i.any_drop) begin
            if (free_out) begin
              cmd_o.emit = 1'b1; cmd_o.last = 1'b1; state_d = SWait;
            end
          end else begin
            cmd_o.restart = 1'b1; state_d = SDrop;
          end
        end else begin
          cmd_o.step  = 1'b1;
          cmd_o.tally = stat_i.expired;
        end
      end
      SDrop: begin
        // drop pass: same walk order, freeing and reporting each expired entry
        if (!stat_i.cur_valid) begin
          state_d = SWait;
        end else if (!stat_i.expired) begin
          cmd_o.step = 1'b1;
        end else if (free_out) begin
          cmd_o.emit = 1'b1; cmd_o.use_cur = 1'b1; cmd_o.drop = 1'b1;
          cmd_o.do_free_cur = 1'b1; cmd_o.step = 1'b1;
          cmd_o.last = stat_i.last_drop;
          if (stat_i.last_drop) state_d = SWait;
        end
      end
      SWait: if (free_out) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == SExec)
    else $error("capture not followed by execute");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.do_alloc || cmd_o.do_set) |-> cmd_o.emit && cmd_o.last)
    else $error("single result command without final word");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.do_free_cur |-> cmd_o.emit && cmd_o.step)
    else $error("sweep drop without report");
endmodule

@@ hdl/pending_transaction_table_core.sv @@
// Top level: pending transaction table with free-slot stack and timeout sweep.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid/in_ready) takes one command word: allocate, find,
//  set status, release or sweep, with its slot, status, addresses, amount
//  and current time. Output channel (out_valid/out_ready) returns result
//  words; the final word of a command has last_o set.
//  Configuration channel (cfg_valid/cfg_ready) writes the 32-bit timeout;
//  write it only while the table is idle.
//  Sequence: a word is captured while idle and executed once the output
//  register is empty; each result word is held in the output register.
//  Allocate, set and release return one word each. Find walks the busy
//  list one entry per cycle. Sweep walks the list twice, first counting
//  expired entries, then freeing and reporting them; each drop waits for
//  the output register to empty. Find and sweep share the single walk
//  cursor through next_link. A sweep with no expired entry reports one
//  word that is zero but for the idle count and last_o. When the receiver
//  stalls, the controller holds its place until the output register
//  empties.
//  Reset: timeout 5000, every slot idle, free stack 0,1,2,... from slot 0.
module pending_transaction_table_core
  import ptt_pkg::*;
#(
  parameter int unsigned SLOTS = SlotsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       command_i,
  input  logic [3:0]       slot_i,
  input  logic [1:0]       entry_status_i,
  input  logic [31:0]      sender_addr_i,
  input  logic [31:0]      receiver_addr_i,
  input  logic [31:0]      amount_in_i,
  input  logic [TimeW-1:0] now_ms_i,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       result_code_o,
  output logic [3:0]       slot_out_o,
  output logic             dropped_o,
  output logic [31:0]      sender_out_o,
  output logic [31:0]      receiver_out_o,
  output logic [31:0]      amount_out_o,
  output logic [4:0]       free_count_o,
  output logic             last_o
);
  ptt_cmd_t  cmd;
  ptt_stat_t stat;

  // timeout register always writable
  assign cfg_ready = 1'b1;

  ptt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready,
    .stat_i(stat), .cmd_o(cmd)
  );

  ptt_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .cfg_valid, .cfg_data,
    .command_i, .slot_i, .entry_status_i, .sender_addr_i, .receiver_addr_i,
    .amount_in_i, .now_ms_i,
    .out_valid, .out_ready,
    .result_code_o, .slot_out_o, .dropped_o, .sender_out_o, .receiver_out_o,
    .amount_out_o, .free_count_o, .last_o
  );
endmodule
